// File: sv/aligned_extent_allocator_core_macros.svh
// ----------------------------------------------------------------------------
// aligned extent allocator assertion macros
// shorthand for clocked assertions with an active-low reset
// ----------------------------------------------------------------------------
`ifndef ALIGNED_EXTENT_ALLOCATOR_CORE_MACROS_SVH
`define ALIGNED_EXTENT_ALLOCATOR_CORE_MACROS_SVH

// same-cycle implication
`define AEA_ASSERT_SAME(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("aea assertion failed");

// next-cycle implication
`define AEA_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("aea assertion failed");

`endif

// File: sv/aea_pkg.sv
// ----------------------------------------------------------------------------
// aea_pkg
// shared types and constants of the aligned extent allocator
// ----------------------------------------------------------------------------
package aea_pkg;

  localparam int unsigned MaxExtents = 64;
  localparam int unsigned IdxW       = $clog2(MaxExtents);
  localparam int unsigned CntW       = $clog2(MaxExtents + 1);

  localparam logic [1:0] StatusOk   = 2'd0;
  localparam logic [1:0] StatusNoFit = 2'd1;
  localparam logic [1:0] StatusFull = 2'd2;

  localparam logic [1:0] RegPoolBase  = 2'd0;
  localparam logic [1:0] RegPoolBytes = 2'd1;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  // one free extent
  typedef struct packed {
    logic [31:0] start;
    logic [31:0] len;
  } ext_t;

endpackage

// File: sv/aea_ext_mem.sv
// ----------------------------------------------------------------------------
// aea_ext_mem
// extent table, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module aea_ext_mem (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [aea_pkg::IdxW-1:0]    waddr_i,
  input  aea_pkg::ext_t               wdata_i,
  input  logic [aea_pkg::IdxW-1:0]    raddr_i,
  output aea_pkg::ext_t               rdata_o
);

  aea_pkg::ext_t mem_q [aea_pkg::MaxExtents];
  aea_pkg::ext_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/aea_fit_unit.sv
// ----------------------------------------------------------------------------
// aea_fit_unit
// alignment pad of one extent and the remainder it would leave
// ----------------------------------------------------------------------------
module aea_fit_unit (
  input  aea_pkg::ext_t        ext_i,
  input  logic [28:0]          actual_i,
  input  logic [16:0]          align_i,
  input  logic [15:0]          offset_i,
  input  logic                 low_i,
  output logic [16:0]          pad_o,
  // remainder path works on registered operands
  input  logic [31:0]          len_i,
  input  logic [16:0]          pad_i,
  output logic signed [33:0]   rem_o
);

  logic [31:0] addr;
  logic [31:0] sum;
  logic [16:0] m;

  always_comb begin
    addr = low_i ? ext_i.start : (ext_i.start + ext_i.len - {3'b0, actual_i});
    sum  = addr + {16'b0, offset_i};
    m    = sum[16:0] & (align_i - 17'd1);
    if (!low_i) begin
      pad_o = m;
    end else if (m == 17'd0) begin
      pad_o = 17'd0;
    end else begin
      pad_o = align_i - m;
    end
  end

  assign rem_o = $signed({2'b0, len_i}) - $signed({5'b0, actual_i})
               - $signed({17'b0, pad_i});

endmodule

// File: sv/aligned_extent_allocator_core.sv
// ----------------------------------------------------------------------------
// aligned_extent_allocator_core
// address-ordered free-extent allocator with first-fit and best-fit choice
// ----------------------------------------------------------------------------
// usage:
//   s_axis carries one request; tuser is the mode (0 allocate, 1 free), tdata
//   holds size, alignment, offset, scan direction, fit choice, free address
//   m_axis carries one result per request; tuser is the status
//   cfg port writes pool_base (index 0) or pool_bytes (index 1); either write
//   reloads the table with the pool extent and clears the allocation counters
// request processing:
//   an allocate reads the table one extent at a time (read, pad, compare)
//   through the shared fit unit, and moves the upper entries down one at a
//   time when an extent is used up
//   a free walks the extents in address order up to the address, then may
//   move the upper entries one at a time for an insert or a removal
//   the single table read port serialises these steps; tready is low meanwhile
// reset:
//   empty table, counters and pool registers zero, no result pending
// stall:
//   a result waits in the output register; the block finishes the request
//   and then holds in its done state until the output register is free
// ----------------------------------------------------------------------------
module aligned_extent_allocator_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  // slave side
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // size[27:0], align[44:28], offset[60:45], from_low_end[61], best_fit[62],
  // free_address[94:63], zero[95]
  input  logic [95:0]   s_axis_tdata,
  // mode[0]
  input  logic [0:0]    s_axis_tuser,
  // master side
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // block_address[31:0], granted_bytes[63:32], live_allocations[95:64],
  // bytes_free[127:96], least_bytes_free[159:128]
  output logic [159:0]  m_axis_tdata,
  // status[1:0]
  output logic [1:0]    m_axis_tuser,
  // configuration
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_index_i,
  input  logic [31:0]   cfg_wdata_i
);

  localparam int unsigned IdxW = aea_pkg::IdxW;
  localparam int unsigned CntW = aea_pkg::CntW;

  typedef enum logic [13:0] {
    S_IDLE  = 14'b00000000000001,
    S_ARD   = 14'b00000000000010,
    S_APAD  = 14'b00000000000100,
    S_ACMP  = 14'b00000000001000,
    S_ADONE = 14'b00000000010000,
    S_RMRD  = 14'b00000000100000,
    S_RMWR  = 14'b00000001000000,
    S_FRD   = 14'b00000010000000,
    S_FEV   = 14'b00000100000000,
    S_FDEC  = 14'b00001000000000,
    S_FMRG  = 14'b00010000000000,
    S_INRD  = 14'b00100000000000,
    S_INWR  = 14'b01000000000000,
    S_DONE  = 14'b10000000000000
  } state_e;

  state_e state_q, state_d;

  // request
  logic [27:0] size_q, size_d;
  logic [16:0] align_q, align_d;
  logic [15:0] off_q, off_d;
  logic        low_q, low_d;
  logic        best_q, best_d;
  logic [31:0] faddr_q, faddr_d;
  logic [28:0] actual_q, actual_d;

  // scan
  logic [CntW-1:0]    k_q, k_d;
  logic [IdxW-1:0]    idx_q, idx_d;
  logic [31:0]        cur_start_q, cur_start_d;
  logic [31:0]        cur_len_q, cur_len_d;
  logic [16:0]        pad_q, pad_d;
  logic               found_q, found_d;
  logic signed [33:0] brem_q, brem_d;
  logic [IdxW-1:0]    bidx_q, bidx_d;
  logic [16:0]        bpad_q, bpad_d;
  logic [31:0]        bstart_q, bstart_d;

  // free walk and table moves
  logic [CntW-1:0] fi_q, fi_d;
  logic [CntW-1:0] j_q, j_d;
  aea_pkg::ext_t   prev_q, prev_d;
  aea_pkg::ext_t   next_q, next_d;
  logic            has_next_q, has_next_d;
  logic [31:0]     merge_len_q, merge_len_d;

  // state of the pool
  logic [CntW-1:0] ext_count_q, ext_count_d;
  logic [31:0]     alloc_cnt_q, alloc_cnt_d;
  logic [31:0]     ba_q, ba_d;
  logic [31:0]     peak_q, peak_d;
  logic            peak_chk_q, peak_chk_d;
  logic [31:0]     base_q, base_d;
  logic [31:0]     bytes_q, bytes_d;

  // result
  logic [1:0]   res_status_q, res_status_d;
  logic [31:0]  res_addr_q, res_addr_d;
  logic [31:0]  res_granted_q, res_granted_d;
  logic         m_valid_q, m_valid_d;
  logic [159:0] m_data_q, m_data_d;
  logic [1:0]   m_user_q, m_user_d;

  // table port
  logic            mem_we;
  logic [IdxW-1:0] mem_waddr;
  aea_pkg::ext_t   mem_wdata;
  logic [IdxW-1:0] mem_raddr;
  aea_pkg::ext_t   mem_rdata;

  // fit unit
  logic [16:0]        fit_pad;
  logic signed [33:0] fit_rem;

  // helpers
  logic [28:0]     rounded;
  logic [31:0]     granted;
  logic            fit_ok;
  logic            mprev, mnext;
  logic [CntW-1:0] scan_idx;
  logic [31:0]     peak_new;

  aea_ext_mem u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  aea_fit_unit u_fit (
    .ext_i    (mem_rdata),
    .actual_i (actual_q),
    .align_i  (align_q),
    .offset_i (off_q),
    .low_i    (low_q),
    .pad_o    (fit_pad),
    .len_i    (cur_len_q),
    .pad_i    (pad_q),
    .rem_o    (fit_rem)
  );

  // a configuration write takes the idle cycle, so no transfer is taken then
  assign s_axis_tready = (state_q == S_IDLE) && !cfg_we_i;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  always_comb begin
    state_d       = state_q;
    size_d        = size_q;
    align_d       = align_q;
    off_d         = off_q;
    low_d         = low_q;
    best_d        = best_q;
    faddr_d       = faddr_q;
    actual_d      = actual_q;
    k_d           = k_q;
    idx_d         = idx_q;
    cur_start_d   = cur_start_q;
    cur_len_d     = cur_len_q;
    pad_d         = pad_q;
    found_d       = found_q;
    brem_d        = brem_q;
    bidx_d        = bidx_q;
    bpad_d        = bpad_q;
    bstart_d      = bstart_q;
    fi_d          = fi_q;
    j_d           = j_q;
    prev_d        = prev_q;
    next_d        = next_q;
    has_next_d    = has_next_q;
    merge_len_d   = merge_len_q;
    ext_count_d   = ext_count_q;
    alloc_cnt_d   = alloc_cnt_q;
    ba_d          = ba_q;
    peak_d        = peak_q;
    peak_chk_d    = peak_chk_q;
    base_d        = base_q;
    bytes_d       = bytes_q;
    res_status_d  = res_status_q;
    res_addr_d    = res_addr_q;
    res_granted_d = res_granted_q;
    m_valid_d     = m_valid_q;
    m_data_d      = m_data_q;
    m_user_d      = m_user_q;

    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_raddr = '0;

    // size rounded up to 4 bytes, at least 16
    rounded = ({1'b0, s_axis_tdata[27:0]} + 29'd3) & 29'h1ffffffc;
    granted = {3'b0, actual_q} + {15'b0, bpad_q};
    fit_ok  = (fit_rem == 34'sd0) || (fit_rem > 34'sd15);
    mprev   = (fi_q != '0) && ((prev_q.start + prev_q.len) == faddr_q);
    mnext   = has_next_q && ((faddr_q + {4'b0, size_q}) == next_q.start);
    scan_idx = low_q ? k_q : (ext_count_q - 1'b1 - k_q);
    peak_new = (peak_chk_q && ($signed(peak_q) < $signed(ba_q))) ? ba_q : peak_q;

    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (cfg_we_i && (cfg_index_i == aea_pkg::RegPoolBase ||
                         cfg_index_i == aea_pkg::RegPoolBytes)) begin
          // reload the table with the whole pool
          if (cfg_index_i == aea_pkg::RegPoolBase) begin
            base_d = cfg_wdata_i;
          end else begin
            bytes_d = cfg_wdata_i;
          end
          mem_we          = 1'b1;
          mem_waddr       = '0;
          mem_wdata.start = base_d;
          mem_wdata.len   = bytes_d;
          ext_count_d     = (bytes_d != 32'd0) ? CntW'(1) : '0;
          alloc_cnt_d     = '0;
          ba_d            = '0;
          peak_d          = '0;
        end else if (s_axis_tvalid && s_axis_tready) begin
          size_d   = s_axis_tdata[27:0];
          align_d  = (s_axis_tdata[44:28] == 17'd0) ? 17'd1 : s_axis_tdata[44:28];
          off_d    = s_axis_tdata[60:45];
          low_d    = s_axis_tdata[61];
          best_d   = s_axis_tdata[62];
          faddr_d  = s_axis_tdata[94:63];
          actual_d = (rounded < 29'h10) ? 29'h10 : rounded;
          k_d      = '0;
          found_d  = 1'b0;
          fi_d     = '0;
          has_next_d = 1'b0;
          if (s_axis_tuser[0] == aea_pkg::MODE_ALLOC) begin
            state_d = S_ARD;
          end else if (s_axis_tdata[27:0] == 28'd0) begin
            // empty free only moves the counters
            alloc_cnt_d   = alloc_cnt_q - 32'd1;
            res_status_d  = aea_pkg::StatusOk;
            res_addr_d    = s_axis_tdata[94:63];
            res_granted_d = '0;
            state_d       = S_DONE;
          end else begin
            state_d = S_FRD;
          end
        end
      end

      S_ARD: begin
        if (k_q == ext_count_q) begin
          state_d = S_ADONE;
        end else begin
          mem_raddr = scan_idx[IdxW-1:0];
          idx_d     = scan_idx[IdxW-1:0];
          state_d   = S_APAD;
        end
      end

      S_APAD: begin
        cur_start_d = mem_rdata.start;
        cur_len_d   = mem_rdata.len;
        pad_d       = fit_pad;
        state_d     = S_ACMP;
      end

      S_ACMP: begin
        k_d     = k_q + 1'b1;
        state_d = S_ARD;
        if (fit_ok && (!found_q || fit_rem < brem_q)) begin
          found_d  = 1'b1;
          brem_d   = fit_rem;
          bidx_d   = idx_q;
          bpad_d   = pad_q;
          bstart_d = cur_start_q;
          if (!best_q) begin
            state_d = S_ADONE;
          end
        end
      end

      S_ADONE: begin
        if (!found_q) begin
          res_status_d  = aea_pkg::StatusNoFit;
          res_addr_d    = '0;
          res_granted_d = '0;
          state_d       = S_DONE;
        end else begin
          res_status_d  = aea_pkg::StatusOk;
          res_granted_d = granted;
          res_addr_d    = low_q ? bstart_q : (bstart_q + brem_q[31:0]);
          alloc_cnt_d   = alloc_cnt_q + 32'd1;
          ba_d          = ba_q + granted;
          peak_chk_d    = 1'b1;
          if (brem_q == 34'sd0) begin
            j_d     = {1'b0, bidx_q};
            state_d = S_RMRD;
          end else begin
            mem_we          = 1'b1;
            mem_waddr       = bidx_q;
            mem_wdata.start = low_q ? (bstart_q + granted) : bstart_q;
            mem_wdata.len   = brem_q[31:0];
            state_d         = S_DONE;
          end
        end
      end

      // close the gap at j by moving the upper entries down
      S_RMRD: begin
        if ((j_q + 1'b1) < ext_count_q) begin
          mem_raddr = IdxW'(j_q + 1'b1);
          state_d   = S_RMWR;
        end else begin
          ext_count_d = ext_count_q - 1'b1;
          state_d     = S_DONE;
        end
      end

      S_RMWR: begin
        mem_we    = 1'b1;
        mem_waddr = j_q[IdxW-1:0];
        mem_wdata = mem_rdata;
        j_d       = j_q + 1'b1;
        state_d   = S_RMRD;
      end

      S_FRD: begin
        if (fi_q < ext_count_q) begin
          mem_raddr = fi_q[IdxW-1:0];
          state_d   = S_FEV;
        end else begin
          state_d = S_FDEC;
        end
      end

      S_FEV: begin
        if (mem_rdata.start <= faddr_q) begin
          prev_d  = mem_rdata;
          fi_d    = fi_q + 1'b1;
          state_d = S_FRD;
        end else begin
          next_d     = mem_rdata;
          has_next_d = 1'b1;
          state_d    = S_FDEC;
        end
      end

      S_FDEC: begin
        res_addr_d    = faddr_q;
        res_granted_d = '0;
        if (!mprev && !mnext && (ext_count_q >= CntW'(aea_pkg::MaxExtents))) begin
          res_status_d = aea_pkg::StatusFull;
          state_d      = S_DONE;
        end else begin
          res_status_d = aea_pkg::StatusOk;
          alloc_cnt_d  = alloc_cnt_q - 32'd1;
          ba_d         = ba_q - {4'b0, size_q};
          if (mprev) begin
            mem_we          = 1'b1;
            mem_waddr       = IdxW'(fi_q - 1'b1);
            mem_wdata.start = prev_q.start;
            mem_wdata.len   = prev_q.len + {4'b0, size_q};
            merge_len_d     = mem_wdata.len;
            state_d         = mnext ? S_FMRG : S_DONE;
          end else if (mnext) begin
            mem_we          = 1'b1;
            mem_waddr       = fi_q[IdxW-1:0];
            mem_wdata.start = faddr_q;
            mem_wdata.len   = next_q.len + {4'b0, size_q};
            state_d         = S_DONE;
          end else begin
            j_d     = ext_count_q;
            state_d = S_INRD;
          end
        end
      end

      // both neighbors merge: fold the upper one in, then remove it
      S_FMRG: begin
        mem_we          = 1'b1;
        mem_waddr       = IdxW'(fi_q - 1'b1);
        mem_wdata.start = prev_q.start;
        mem_wdata.len   = merge_len_q + next_q.len;
        j_d             = fi_q;
        state_d         = S_RMRD;
      end

      // open a gap at fi by moving the upper entries up
      S_INRD: begin
        if (j_q > fi_q) begin
          mem_raddr = IdxW'(j_q - 1'b1);
          state_d   = S_INWR;
        end else begin
          mem_we          = 1'b1;
          mem_waddr       = fi_q[IdxW-1:0];
          mem_wdata.start = faddr_q;
          mem_wdata.len   = {4'b0, size_q};
          ext_count_d     = ext_count_q + 1'b1;
          state_d         = S_DONE;
        end
      end

      S_INWR: begin
        mem_we    = 1'b1;
        mem_waddr = j_q[IdxW-1:0];
        mem_wdata = mem_rdata;
        j_d       = j_q - 1'b1;
        state_d   = S_INRD;
      end

      S_DONE: begin
        peak_d     = peak_new;
        peak_chk_d = 1'b0;
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_user_d  = res_status_q;
          m_data_d  = {bytes_q - peak_new, bytes_q - ba_q, alloc_cnt_q,
                       res_granted_q, res_addr_q};
          state_d   = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ext_count_q <= '0;
      alloc_cnt_q <= '0;
      ba_q        <= '0;
      peak_q      <= '0;
      peak_chk_q  <= 1'b0;
      base_q      <= '0;
      bytes_q     <= '0;
      m_valid_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      ext_count_q <= ext_count_d;
      alloc_cnt_q <= alloc_cnt_d;
      ba_q        <= ba_d;
      peak_q      <= peak_d;
      peak_chk_q  <= peak_chk_d;
      base_q      <= base_d;
      bytes_q     <= bytes_d;
      m_valid_q   <= m_valid_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    size_q        <= size_d;
    align_q       <= align_d;
    off_q         <= off_d;
    low_q         <= low_d;
    best_q        <= best_d;
    faddr_q       <= faddr_d;
    actual_q      <= actual_d;
    k_q           <= k_d;
    idx_q         <= idx_d;
    cur_start_q   <= cur_start_d;
    cur_len_q     <= cur_len_d;
    pad_q         <= pad_d;
    found_q       <= found_d;
    brem_q        <= brem_d;
    bidx_q        <= bidx_d;
    bpad_q        <= bpad_d;
    bstart_q      <= bstart_d;
    fi_q          <= fi_d;
    j_q           <= j_d;
    prev_q        <= prev_d;
    next_q        <= next_d;
    has_next_q    <= has_next_d;
    merge_len_q   <= merge_len_d;
    res_status_q  <= res_status_d;
    res_addr_q    <= res_addr_d;
    res_granted_q <= res_granted_d;
    m_data_q      <= m_data_d;
    m_user_q      <= m_user_d;
  end

endmodule

// File: sv/aea_checker.sv
// ----------------------------------------------------------------------------
// aea_checker
// port-level checks of the aligned extent allocator
// ----------------------------------------------------------------------------
`include "aligned_extent_allocator_core_macros.svh"

module aea_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [159:0] m_axis_tdata,
  input logic [1:0]   m_axis_tuser
);

  `AEA_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  `AEA_ASSERT_NEXT(a_busy_after_transfer, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  `AEA_ASSERT_SAME(a_status_code, m_axis_tvalid, m_axis_tuser != 2'd3)
  `AEA_ASSERT_SAME(a_fail_no_grant, m_axis_tvalid && m_axis_tuser != aea_pkg::StatusOk,
                   m_axis_tdata[63:32] == 32'd0)

endmodule

bind aligned_extent_allocator_core aea_checker u_aea_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
